### rtl/oaht_pkg.sv
// shared types and constants for the open addressing hash table
// no dependencies; compiled first

package oaht_pkg;

  localparam int unsigned OAHT_CAPACITY   = 256;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned HASH_W          = 32;
  localparam int unsigned VALUE_W         = 64;
  localparam int unsigned LIMIT_W         = 9;
  localparam int unsigned COUNT_W         = 9;
  localparam int unsigned LOAD_LIMIT_RST  = 192;
  localparam int unsigned HASH_STEP_BITS  = 8;
  localparam int unsigned HASH_STEPS      = HASH_W / HASH_STEP_BITS;
  localparam int unsigned HASH_STEP_CNT_W = $clog2(HASH_STEPS);

  typedef enum logic [OP_W-1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_DEL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_FULL  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_ISSUE,
    ST_PROBE,
    ST_FINISH
  } state_e;

endpackage

### rtl/oaht_req_if.sv
// request channel: valid/ready plus operation, key and value payload
// depends on oaht_pkg

interface oaht_req_if import oaht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   key_id;
  logic [HASH_W-1:0]  key_hash;
  logic [VALUE_W-1:0] write_value;

  modport source (output valid, output operation, output key_id, output key_hash,
                  output write_value, input ready);
  modport sink   (input valid, input operation, input key_id, input key_hash,
                  input write_value, output ready);
endinterface

### rtl/oaht_rsp_if.sv
// response channel: valid/ready plus hit, read value and full flags
// depends on oaht_pkg

interface oaht_rsp_if import oaht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit_flag;
  logic [VALUE_W-1:0] read_value;
  logic               table_full;

  modport source (output valid, output hit_flag, output read_value, output table_full,
                  input ready);
  modport sink   (input valid, input hit_flag, input read_value, input table_full,
                  output ready);
endinterface

### rtl/oaht_slot_mem.sv
// slot storage: tag memory and key/value memory, one write and one
// registered read port each; depends on oaht_pkg

module oaht_slot_mem import oaht_pkg::*; #(
  parameter int unsigned CAPACITY = OAHT_CAPACITY
) (
  input  logic                        clk_i,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr_i,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr_i,
  input  logic                        tag_we_i,
  input  tag_e                        tag_wdata_i,
  input  logic                        kv_we_i,
  input  logic [KEY_W-1:0]            key_wdata_i,
  input  logic [VALUE_W-1:0]          val_wdata_i,
  output tag_e                        tag_rdata_o,
  output logic [KEY_W-1:0]            key_rdata_o,
  output logic [VALUE_W-1:0]          val_rdata_o
);

  tag_e                         tag_mem [CAPACITY];
  logic [KEY_W+VALUE_W-1:0]     kv_mem  [CAPACITY];
  logic [KEY_W+VALUE_W-1:0]     kv_rd_q;

  always_ff @(posedge clk_i) begin
    if (tag_we_i) begin
      tag_mem[wr_addr_i] <= tag_wdata_i;
    end
    tag_rdata_o <= tag_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we_i) begin
      kv_mem[wr_addr_i] <= {key_wdata_i, val_wdata_i};
    end
    kv_rd_q <= kv_mem[rd_addr_i];
  end

  assign key_rdata_o = kv_rd_q[KEY_W+VALUE_W-1:VALUE_W];
  assign val_rdata_o = kv_rd_q[VALUE_W-1:0];

endmodule

### rtl/open_addressing_hash_table.sv
// linear probing hash map with tombstones: probe sequencer and top level
// depends on oaht_pkg, oaht_req_if, oaht_rsp_if, oaht_slot_mem
//
// usage:
//   req_i carries get, set or delete requests (operation, key_id, key_hash,
//   write_value); rsp_o returns one response per request (hit_flag,
//   read_value, table_full). both are valid/ready channels. load_limit is
//   written through cfg_we_i/cfg_wdata_i; the user must write it only while
//   the block is idle, which the block itself does not enforce. one request
//   is worked on at a time; a request probes one slot per cycle, bounded by
//   the single read port of the slot memory. when CAPACITY is not a power of
//   two, the hash is first reduced in the hash state. a get or delete on an
//   empty map, a set over the load limit and an unknown operation go straight
//   to the finish state without probing. after probing, the finish state
//   loads the response into the output register once that is free.
//   after reset the tag memory is swept to empty, one slot per cycle, over
//   all CAPACITY slots (256 by default); req_i.ready stays low meanwhile.
//   the response sits in an output register: a new request is taken while
//   it waits, but the next response is held back until rsp_o.ready frees it.

module open_addressing_hash_table import oaht_pkg::*; #(
  parameter int unsigned CAPACITY = OAHT_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  oaht_req_if.sink           req_i,
  oaht_rsp_if.source         rsp_o,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i
);

  localparam int unsigned    IdxW    = $clog2(CAPACITY);
  localparam bit             CapPow2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [IdxW:0]  CapWide = (IdxW+1)'(CAPACITY);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [HASH_STEP_CNT_W-1:0] LastStep = HASH_STEP_CNT_W'(HASH_STEPS - 1);

  state_e                     state_q, state_d;
  logic [IdxW-1:0]            clr_idx_q, clr_idx_d;
  logic [COUNT_W-1:0]         count_q, count_d;
  logic [LIMIT_W-1:0]         limit_q;
  logic                       rsp_valid_q, rsp_valid_d;

  logic [OP_W-1:0]            op_q, op_d;
  logic [KEY_W-1:0]           key_q, key_d;
  logic [VALUE_W-1:0]         wval_q, wval_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [IdxW-1:0]            n_q, n_d;
  logic [IdxW-1:0]            rem_q, rem_d;
  logic [HASH_W-1:0]          hash_sh_q, hash_sh_d;
  logic [HASH_STEP_CNT_W-1:0] step_q, step_d;
  logic [IdxW-1:0]            tomb_q, tomb_d;
  logic                       tomb_vld_q, tomb_vld_d;
  logic                       matched_q, matched_d;
  logic                       slot_ok_q, slot_ok_d;
  logic                       slot_empty_q, slot_empty_d;
  logic [IdxW-1:0]            slot_q, slot_d;
  logic [VALUE_W-1:0]         val_q, val_d;

  logic                       hit_q, full_q;
  logic [VALUE_W-1:0]         rval_q;
  logic                       rsp_load;
  logic                       hit_nxt, full_nxt;
  logic [VALUE_W-1:0]         rval_nxt;

  logic [IdxW-1:0]            rd_addr, wr_addr, idx_nxt, rem_nxt;
  logic [IdxW:0]              rem_tmp;
  logic                       tag_we, kv_we, probe_go, probe_done;
  tag_e                       tag_wdata, tag_rd;
  logic [KEY_W-1:0]           key_rd;
  logic [VALUE_W-1:0]         val_rd;
  logic                       is_get, is_set, is_del;

  oaht_slot_mem #(
    .CAPACITY (CAPACITY)
  ) u_slot_mem (
    .clk_i       (clk_i),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .tag_we_i    (tag_we),
    .tag_wdata_i (tag_wdata),
    .kv_we_i     (kv_we),
    .key_wdata_i (key_q),
    .val_wdata_i (wval_q),
    .tag_rdata_o (tag_rd),
    .key_rdata_o (key_rd),
    .val_rdata_o (val_rd)
  );

  // hash reduction, eight bits a cycle: r = (2r + b) mod CAPACITY
  always_comb begin
    rem_tmp = '0;
    rem_nxt = rem_q;
    for (int b = 0; b < HASH_STEP_BITS; b++) begin
      rem_tmp = {rem_nxt, hash_sh_q[HASH_W-1-b]};
      if (rem_tmp >= CapWide) begin
        rem_tmp = rem_tmp - CapWide;
      end
      rem_nxt = rem_tmp[IdxW-1:0];
    end
  end

  assign idx_nxt = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign is_get  = (op_q == OP_GET);
  assign is_set  = (op_q == OP_SET);
  assign is_del  = (op_q == OP_DEL);

  assign hit_nxt  = ((is_get || is_del) && matched_q) || (is_set && slot_ok_q && !matched_q);
  assign full_nxt = is_set && !slot_ok_q;
  assign rval_nxt = (is_get && matched_q) ? val_q : '0;

  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    count_d      = count_q;
    op_d         = op_q;
    key_d        = key_q;
    wval_d       = wval_q;
    idx_d        = idx_q;
    n_d          = n_q;
    rem_d        = rem_q;
    hash_sh_d    = hash_sh_q;
    step_d       = step_q;
    tomb_d       = tomb_q;
    tomb_vld_d   = tomb_vld_q;
    matched_d    = matched_q;
    slot_ok_d    = slot_ok_q;
    slot_empty_d = slot_empty_q;
    slot_d       = slot_q;
    val_d        = val_q;
    rd_addr      = idx_q;
    wr_addr      = slot_q;
    tag_we       = 1'b0;
    tag_wdata    = TAG_EMPTY;
    kv_we        = 1'b0;
    rsp_load     = 1'b0;
    probe_go     = 1'b0;
    probe_done   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        wr_addr   = clr_idx_q;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          op_d         = req_i.operation;
          key_d        = req_i.key_id;
          wval_d       = req_i.write_value;
          hash_sh_d    = req_i.key_hash;
          idx_d        = req_i.key_hash[IdxW-1:0];
          rem_d        = '0;
          step_d       = '0;
          n_d          = '0;
          tomb_vld_d   = 1'b0;
          matched_d    = 1'b0;
          slot_ok_d    = 1'b0;
          slot_empty_d = 1'b0;
          case (req_i.operation) inside
            OP_GET, OP_DEL: probe_go = (count_q != '0);
            OP_SET:         probe_go = ({1'b0, count_q} + 1'b1) <= {1'b0, limit_q};
            default:        probe_go = 1'b0;
          endcase
          if (!probe_go) begin
            state_d = ST_FINISH;
          end else if (CapPow2) begin
            state_d = ST_ISSUE;
          end else begin
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        rem_d     = rem_nxt;
        hash_sh_d = hash_sh_q << HASH_STEP_BITS;
        step_d    = step_q + 1'b1;
        if (step_q == LastStep) begin
          idx_d   = rem_nxt;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        // read of the following slot overlaps the check of this one
        rd_addr = idx_nxt;
        idx_d   = idx_nxt;
        n_d     = n_q + 1'b1;
        unique case (tag_rd)
          TAG_FULL: begin
            if (key_rd == key_q) begin
              matched_d  = 1'b1;
              slot_ok_d  = 1'b1;
              slot_d     = idx_q;
              val_d      = val_rd;
              probe_done = 1'b1;
            end
          end
          TAG_TOMB: begin
            if (!tomb_vld_q) begin
              tomb_vld_d = 1'b1;
              tomb_d     = idx_q;
            end
          end
          default: begin
            slot_ok_d    = 1'b1;
            slot_empty_d = !tomb_vld_q;
            slot_d       = tomb_vld_q ? tomb_q : idx_q;
            probe_done   = 1'b1;
          end
        endcase
        // whole table walked: fall back to the first tombstone
        if (!probe_done && n_q == LastIdx) begin
          slot_ok_d  = tomb_vld_d;
          slot_d     = tomb_d;
          probe_done = 1'b1;
        end
        if (probe_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          wr_addr  = slot_q;
          if (is_set && slot_ok_q) begin
            tag_we    = 1'b1;
            tag_wdata = TAG_FULL;
            kv_we     = 1'b1;
            if (!matched_q && slot_empty_q) begin
              count_d = count_q + 1'b1;
            end
          end else if (is_del && matched_q) begin
            tag_we    = 1'b1;
            tag_wdata = TAG_TOMB;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      count_q     <= '0;
      limit_q     <= LIMIT_W'(LOAD_LIMIT_RST);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    wval_q       <= wval_d;
    idx_q        <= idx_d;
    n_q          <= n_d;
    rem_q        <= rem_d;
    hash_sh_q    <= hash_sh_d;
    step_q       <= step_d;
    tomb_q       <= tomb_d;
    tomb_vld_q   <= tomb_vld_d;
    matched_q    <= matched_d;
    slot_ok_q    <= slot_ok_d;
    slot_empty_q <= slot_empty_d;
    slot_q       <= slot_d;
    val_q        <= val_d;
    if (rsp_load) begin
      hit_q  <= hit_nxt;
      rval_q <= rval_nxt;
      full_q <= full_nxt;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit_flag   = hit_q;
  assign rsp_o.read_value = rval_q;
  assign rsp_o.table_full = full_q;

`ifndef ASSERT_OFF
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
    else $error("occupancy count moved by more than one");

  a_count_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == ST_FINISH))
    else $error("occupancy count changed outside finish");

  a_rsp_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("response raised without a finished request");

  a_no_transfer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !req_i.ready)
    else $error("request taken during tag sweep");
`endif

endmodule

### tb/sv/tb.sv
// testbench for open_addressing_hash_table: directed and random get/set/delete traffic
// checked against an in-bench linear probing predictor with tombstones and load limit
// depends on oaht_pkg, oaht_req_if, oaht_rsp_if and the rtl top level
`timescale 1ns / 100ps

module tb import oaht_pkg::*; ();

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int WATCHDOG_CYCLES = 6000;
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 16;
  localparam int POOL_SIZE       = 64;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam logic [KEY_W-1:0] KEY_A = 32'h1234_5678;
  localparam logic [KEY_W-1:0] KEY_B = 32'hA5A5_0F0F;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value;
    logic               full;
  } table_rsp_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
  } key_ref_t;

  class table_scoreboard;
    tag_e               slot_tag[OAHT_CAPACITY];
    logic [KEY_W-1:0]   slot_key[OAHT_CAPACITY];
    logic [VALUE_W-1:0] slot_value[OAHT_CAPACITY];
    int unsigned        occupancy;
    int unsigned        load_limit;
    table_rsp_t         pending_rsp[$];
    bit                 last_refused;
    int                 mismatches;
    int                 checked;
    int                 hits;
    int                 refusals;
    int                 wrapped_probes;

    function new();
      foreach (slot_tag[i]) begin
        slot_tag[i]   = TAG_EMPTY;
        slot_key[i]   = '0;
        slot_value[i] = '0;
      end
      occupancy      = 0;
      load_limit     = LOAD_LIMIT_RST;
      last_refused   = 0;
      mismatches     = 0;
      checked        = 0;
      hits           = 0;
      refusals       = 0;
      wrapped_probes = 0;
    endfunction

    function void set_load_limit(logic [LIMIT_W-1:0] limit);
      load_limit = limit;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    // linear probe: stop at key or empty slot, remember first tombstone
    function int find_slot(logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash,
                           output bit matched);
      int idx;
      int tomb;
      idx     = int'(hash % OAHT_CAPACITY);
      tomb    = -1;
      matched = 0;
      for (int n = 0; n < OAHT_CAPACITY; n++) begin
        if (slot_tag[idx] == TAG_FULL) begin
          if (slot_key[idx] == key) begin
            matched = 1;
            return idx;
          end
        end else if (slot_tag[idx] == TAG_TOMB) begin
          if (tomb < 0) tomb = idx;
        end else begin
          return (tomb >= 0) ? tomb : idx;
        end
        idx = (idx + 1) % OAHT_CAPACITY;
      end
      wrapped_probes++;
      return tomb;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [HASH_W-1:0] hash, logic [VALUE_W-1:0] wdata);
      table_rsp_t rsp;
      int         slot;
      bit         matched;
      rsp = '0;
      case (op)
        OP_GET: begin
          if (occupancy != 0) begin
            slot = find_slot(key, hash, matched);
            if (slot >= 0 && matched) begin
              rsp.hit   = 1'b1;
              rsp.value = slot_value[slot];
            end
          end
        end
        OP_SET: begin
          if (occupancy + 1 > load_limit) begin
            rsp.full = 1'b1;
          end else begin
            slot = find_slot(key, hash, matched);
            if (slot < 0) begin
              rsp.full = 1'b1;
            end else begin
              if (!matched) begin
                rsp.hit = 1'b1;
                if (slot_tag[slot] == TAG_EMPTY) occupancy++;
              end
              slot_tag[slot]   = TAG_FULL;
              slot_key[slot]   = key;
              slot_value[slot] = wdata;
            end
          end
        end
        OP_DEL: begin
          if (occupancy != 0) begin
            slot = find_slot(key, hash, matched);
            if (slot >= 0 && matched) begin
              slot_tag[slot] = TAG_TOMB;
              rsp.hit        = 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (rsp.hit) hits++;
      if (rsp.full) refusals++;
      last_refused = rsp.full;
      pending_rsp.push_back(rsp);
    endfunction

    task report_mismatch(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
      mismatches++;
      $display("mismatch on %s at response %0d: got %h want %h", what, checked, got, want);
    endtask

    task check_response(logic hit, logic [VALUE_W-1:0] rdata, logic full);
      table_rsp_t want;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with nothing outstanding", '0, '0);
        return;
      end
      want = pending_rsp.pop_front();
      checked++;
      if (hit !== want.hit) report_mismatch("hit_flag", VALUE_W'(hit), VALUE_W'(want.hit));
      if (rdata !== want.value) report_mismatch("read_value", rdata, want.value);
      if (full !== want.full) report_mismatch("table_full", VALUE_W'(full), VALUE_W'(want.full));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_wdata_i;

  oaht_req_if req_if ();
  oaht_rsp_if rsp_if ();

  open_addressing_hash_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  table_scoreboard sb = new();

  key_ref_t    key_pool[$];
  key_ref_t    known_keys[$];
  int          burst_left = 0;
  int          requests_sent = 0;
  int          limits_written = 0;
  int          holdoff_requests = 0;
  int          holdoff_served = 0;
  int          holdoff_left = 0;
  int          pattern_age = 0;
  logic [15:0] ready_pattern = '1;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // receiver: rotating stall pattern, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (holdoff_served != holdoff_requests) begin
      holdoff_served = holdoff_requests;
      holdoff_left   = HOLDOFF_CYCLES;
    end
    if (pattern_age == 0) begin
      pattern_age   = $urandom_range(16, 128);
      ready_pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
    end
    pattern_age--;
    if (holdoff_left > 0) begin
      holdoff_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready  <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_response(rsp_if.hit_flag, rsp_if.read_value, rsp_if.table_full);
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                              logic [HASH_W-1:0] hash, logic [VALUE_W-1:0] wdata);
    key_ref_t ref_entry;
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.key_id      <= key;
    req_if.key_hash    <= hash;
    req_if.write_value <= wdata;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(op, key, hash, wdata);
    if (op == OP_SET) begin
      ref_entry.key  = key;
      ref_entry.hash = hash;
      known_keys.push_back(ref_entry);
    end
    burst_left--;
    requests_sent++;
  endtask

  task automatic drain_requests();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_load_limit(logic [LIMIT_W-1:0] limit);
    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_load_limit(limit);
    limits_written++;
  endtask

  // clustered hashes so probe runs get long and wrap past the last slot
  task automatic build_key_pool(bit from_known);
    key_ref_t entry;
    int       base;
    int       spread;
    key_pool.delete();
    base   = $urandom_range(0, OAHT_CAPACITY - 1);
    spread = $urandom_range(8, 80);
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (from_known && known_keys.size() > 0) begin
        entry = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else begin
        entry.key  = $urandom;
        entry.hash = ($urandom & 32'hFFFF_FF00) |
                     ((base + $urandom_range(0, spread)) % OAHT_CAPACITY);
      end
      key_pool.push_back(entry);
    end
  endtask

  task automatic send_random();
    int                 pick;
    key_ref_t           entry;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] wdata;
    pick  = $urandom_range(0, 99);
    entry = key_pool[$urandom_range(0, key_pool.size() - 1)];
    wdata = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) wdata = $urandom_range(0, 1) ? '1 : '0;
    if (pick < 30) op = OP_GET;
    else if (pick < 62) op = OP_SET;
    else if (pick < 88) op = OP_DEL;
    else if (pick < 92) op = OP_UNKNOWN;
    else begin
      op         = OP_W'($urandom_range(0, 3));
      entry.key  = $urandom;
      entry.hash = $urandom;
    end
    send_request(op, entry.key, entry.hash, wdata);
  endtask

  task automatic run_items(int count, bit from_known, bit with_holdoff);
    build_key_pool(from_known);
    for (int i = 0; i < count; i++) begin
      if (with_holdoff && i == count / 3) holdoff_requests++;
      if (i == count / 2 || $urandom_range(0, 199) == 0) drain_requests();
      send_random();
    end
  endtask

  task automatic run_phase(logic [LIMIT_W-1:0] limit, int count, bit from_known,
                           bit with_holdoff);
    write_load_limit(limit);
    run_items(count, from_known, with_holdoff);
  endtask

  // fresh keys until every slot is full or tombstone and a set finds no slot
  task automatic fill_table();
    do begin
      send_request(OP_SET, $urandom, $urandom, {$urandom, $urandom});
    end while (!(sb.occupancy == OAHT_CAPACITY && sb.last_refused));
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    req_if.valid       <= 1'b0;
    req_if.operation   <= '0;
    req_if.key_id      <= '0;
    req_if.key_hash    <= '0;
    req_if.write_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty map, extremes, wrap, overwrite, tombstones
    send_request(OP_GET, KEY_A, 32'h0000_0010, '1);
    send_request(OP_DEL, KEY_A, 32'h0000_0010, '0);
    send_request(OP_UNKNOWN, '1, '1, '1);
    send_request(OP_SET, '0, '0, '0);
    send_request(OP_SET, '1, '1, '1);
    send_request(OP_SET, KEY_A, 32'h0000_00FF, 64'h0123_4567_89AB_CDEF);
    send_request(OP_GET, KEY_A, 32'h0000_00FF, '0);
    send_request(OP_GET, '1, '1, '0);
    send_request(OP_SET, '0, '0, 64'hFEDC_BA98_7654_3210);
    send_request(OP_GET, '0, '0, '1);
    send_request(OP_DEL, '1, '1, '0);
    send_request(OP_GET, '1, '1, '0);
    send_request(OP_GET, KEY_A, 32'h0000_00FF, '0);
    send_request(OP_DEL, '1, '1, '0);
    send_request(OP_SET, KEY_B, 32'h8000_01FF, 64'h5555_AAAA_5555_AAAA);
    send_request(OP_GET, KEY_B, 32'h8000_01FF, '0);
    send_request(OP_SET, '1, '1, 64'h8000_0000_0000_0001);
    send_request(OP_UNKNOWN, '0, '0, '0);
    send_request(OP_DEL, '0, '0, '0);
    send_request(OP_SET, '0, 32'h0000_0080, 64'hAAAA_5555_AAAA_5555);
    send_request(OP_GET, '0, '0, '0);
    send_request(OP_GET, '0, 32'h0000_0080, '0);

    run_phase(9'd100, 280, 1'b0, 1'b0);
    run_phase(9'd1, 60, 1'b1, 1'b0);
    run_phase(9'd0, 40, 1'b1, 1'b0);
    run_phase(9'd192, 320, 1'b0, 1'b1);
    write_load_limit(9'd511);
    fill_table();
    run_items(150, 1'b1, 1'b1);
    run_phase(9'd256, 100, 1'b1, 1'b0);
    run_phase(LIMIT_W'($urandom_range(0, 511)), 100, 1'b0, 1'b0);

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran %0d requests over %0d load limits: %0d hits, %0d refused sets",
             requests_sent, limits_written + 1, sb.hits, sb.refusals);
    $display("%0d responses checked, %0d full-length probes, %0d mismatches",
             sb.checked, sb.wrapped_probes, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/oaht_pkg.sv
rtl/oaht_req_if.sv
rtl/oaht_rsp_if.sv
rtl/oaht_slot_mem.sv
rtl/open_addressing_hash_table.sv
tb/sv/tb.sv
